// File: design/ffca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffca_pkg: shared types and constants
// Sizes, header layout, codes and channel payloads of the first-fit
// coalescing allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

  // Heap geometry
  localparam int HEAP_BYTES_MAX = 65536;
  localparam int ALIGN_BYTES    = 8;
  localparam int SLOTS          = HEAP_BYTES_MAX / ALIGN_BYTES;
  localparam int SLOT_W         = $clog2(SLOTS);
  localparam int LINK_W         = SLOT_W + 1;   // slot index plus "none" code
  localparam int SIZE_W         = SLOT_W + 1;   // block size in slots, up to SLOTS
  localparam int ALIGN_W        = $clog2(ALIGN_BYTES);
  localparam int BYTES_W        = 17;

  localparam logic [LINK_W-1:0] LINK_NONE = '1;

  // Configuration register indexes
  localparam logic [1:0] CFG_HEAP_BASE    = 2'd0;
  localparam logic [1:0] CFG_HEAP_BYTES   = 2'd1;
  localparam logic [1:0] CFG_HEADER_BYTES = 2'd2;

  // Request kinds
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_ALLOC_FAIL  = 2'd1,
    ST_FREE_REJECT = 2'd2
  } status_t;

  // One block header as kept in the header memory
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [LINK_W-1:0] next;
    logic              alloc;
  } hdr_t;

  typedef struct packed {
    logic [31:0] heap_base;
    logic [16:0] heap_bytes;
    logic [6:0]  header_bytes;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic [15:0] request_size;
    logic [31:0] block_address;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] address;
    logic [16:0] free_bytes;
    logic [16:0] min_free_bytes;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT_END,
    S_INIT_HEAD,
    S_DISPATCH,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_ALLOC_LINK,
    S_ALLOC_BLK,
    S_ALLOC_SPLIT,
    S_FREE_RD,
    S_FREE_CHK,
    S_INS_START,
    S_INS_CMP,
    S_INS_WALK,
    S_INS_MERGE,
    S_INS_NX,
    S_INS_NXRD,
    S_INS_WCUR,
    S_INS_LINK,
    S_FINISH
  } state_t;

  // Controller to top level: result beat and heap status
  typedef struct packed {
    logic res_valid;
    logic heap_ready;
  } ctrl_stat_t;

endpackage
`default_nettype wire

// File: design/ffca_hdr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffca_hdr_ram: header memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffca_hdr_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 29
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/ffca_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffca_ctrl: allocator sequencer
// Walks the address-ordered free list in header memory, splits, unlinks,
// inserts and merges blocks; keeps list head, end marker and byte counts.
// ----------------------------------------------------------------------------
module ffca_ctrl import ffca_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_t        in_data,
  input  wire logic       res_ready,
  output out_t            res_data,
  output ctrl_stat_t      stat
);

  state_t state, state_next;

  // Header memory port
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  hdr_t              mem_wdata;
  logic [SLOT_W-1:0] mem_raddr;
  hdr_t              mem_rdata;
  logic [$bits(hdr_t)-1:0] rdata_raw;

  // Heap state
  logic [LINK_W-1:0]  head;
  logic [SLOT_W-1:0]  end_mark;
  logic [BYTES_W-1:0] bytes_free;
  logic [BYTES_W-1:0] min_free;
  logic               heap_ready;

  // Request
  in_t                req;
  logic [1:0]         res_status;
  logic [31:0]        res_addr;

  // Allocate walk
  logic [SIZE_W-1:0]  want_slots;
  logic [SLOT_W-1:0]  blk;
  hdr_t               blk_hdr;
  logic [SLOT_W-1:0]  prev;
  logic               prev_start;
  hdr_t               prev_hdr;

  // Insert walk
  logic [SLOT_W-1:0]  ins_blk;
  logic [SIZE_W-1:0]  ins_size;
  logic [SLOT_W-1:0]  it;
  logic               it_start;
  hdr_t               it_hdr;
  logic [LINK_W-1:0]  n;
  logic [SLOT_W-1:0]  cur;
  logic [SIZE_W-1:0]  cursz;
  logic [LINK_W-1:0]  curnext;
  logic               merged;

  ffca_hdr_ram #(
    .DEPTH (SLOTS),
    .WIDTH ($bits(hdr_t))
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata_raw)
  );
  assign mem_rdata = hdr_t'(rdata_raw);

  // --------------------------------------------------------------------------
  // Heap layout from configuration
  localparam logic [32:0] AMASK33 = 33'(ALIGN_BYTES - 1);
  localparam logic [16:0] AMASK17 = 17'(ALIGN_BYTES - 1);

  logic [32:0]        aligned;
  logic [16:0]        adj;
  logic [16:0]        total_clamp;
  logic [16:0]        total;
  logic [16:0]        endoff;
  logic [16:0]        end_slots;
  logic [SLOT_W-1:0]  end_idx;

  always_comb begin
    aligned     = ({1'b0, cfg.heap_base} + AMASK33) & ~AMASK33;
    adj         = 17'(aligned - {1'b0, cfg.heap_base});
    total_clamp = (cfg.heap_bytes > 17'(HEAP_BYTES_MAX)) ? 17'(HEAP_BYTES_MAX)
                                                          : cfg.heap_bytes;
    total       = (total_clamp > adj) ? (total_clamp - adj) : '0;
    endoff      = (total > 17'(cfg.header_bytes))
                  ? ((total - 17'(cfg.header_bytes)) & ~AMASK17) : '0;
    end_slots   = endoff >> ALIGN_W;
    end_idx     = (end_slots >= 17'(SLOTS)) ? '0 : end_slots[SLOT_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Request decode
  logic [16:0] want_raw;
  logic [16:0] want_rnd;
  logic        want_fail;
  logic [33:0] low;
  logic [33:0] rel;
  logic        addr_bad;
  logic [SLOT_W-1:0] free_blk;

  always_comb begin
    want_raw  = 17'(req.request_size) + 17'(cfg.header_bytes);
    want_rnd  = (want_raw + AMASK17) & ~AMASK17;
    want_fail = (req.request_size == '0) || (want_rnd > bytes_free);
    low       = 34'(aligned) + 34'(cfg.header_bytes);
    rel       = 34'(req.block_address) - low;
    addr_bad  = (34'(req.block_address) < low)
             || (rel[ALIGN_W-1:0] != '0)
             || ((rel >> ALIGN_W) >= 34'(SLOTS));
    free_blk  = rel[ALIGN_W +: SLOT_W];
  end

  // Allocate checks on the header just read
  logic              chk_continue;
  logic              chk_fail;
  logic [SIZE_W-1:0] diff;
  logic              split;
  logic [SLOT_W-1:0] nb;
  logic [SIZE_W-1:0] final_size;
  logic [BYTES_W-1:0] free_after_alloc;
  logic [31:0]       alloc_addr;
  logic              free_bad;

  always_comb begin
    chk_continue = (mem_rdata.size < want_slots) && (mem_rdata.next != LINK_NONE);
    chk_fail     = (blk == end_mark) || (mem_rdata.size < want_slots);
    diff         = blk_hdr.size - want_slots;
    split        = 17'({diff, {ALIGN_W{1'b0}}}) > 17'({cfg.header_bytes, 1'b0});
    nb           = blk + want_slots[SLOT_W-1:0];
    final_size   = split ? want_slots : blk_hdr.size;
    free_after_alloc = bytes_free - {final_size, {ALIGN_W{1'b0}}};
    alloc_addr   = 32'(aligned + (33'(blk) << ALIGN_W) + 33'(cfg.header_bytes));
    free_bad     = (mem_rdata.alloc == 1'b0) || (mem_rdata.next != LINK_NONE);
  end

  // Insert checks
  logic n_lt;
  logic it_adj;
  logic nx_adj;

  always_comb begin
    n_lt   = n < {1'b0, ins_blk};
    it_adj = !it_start && ((15'(it) + 15'(it_hdr.size)) == 15'(ins_blk));
    nx_adj = (n != LINK_NONE) && ((15'(cur) + 15'(cursz)) == 15'(n));
  end

  // --------------------------------------------------------------------------
  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:        if (in_valid) state_next = heap_ready ? S_DISPATCH : S_INIT_END;
      S_INIT_END:    state_next = S_INIT_HEAD;
      S_INIT_HEAD:   state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (req.action == ACT_ALLOC) begin
          state_next = want_fail ? S_FINISH : S_ALLOC_RD;
        end else begin
          state_next = (req.block_address == '0 || addr_bad) ? S_FINISH : S_FREE_RD;
        end
      end
      S_ALLOC_RD:    state_next = S_ALLOC_CHK;
      S_ALLOC_CHK: begin
        if (chk_continue)  state_next = S_ALLOC_RD;
        else if (chk_fail) state_next = S_FINISH;
        else               state_next = S_ALLOC_LINK;
      end
      S_ALLOC_LINK:  state_next = S_ALLOC_BLK;
      S_ALLOC_BLK:   state_next = split ? S_ALLOC_SPLIT : S_FINISH;
      S_ALLOC_SPLIT: state_next = S_INS_START;
      S_FREE_RD:     state_next = S_FREE_CHK;
      S_FREE_CHK:    state_next = free_bad ? S_FINISH : S_INS_START;
      S_INS_START:   state_next = S_INS_CMP;
      S_INS_CMP:     state_next = n_lt ? S_INS_WALK : S_INS_MERGE;
      S_INS_WALK:    state_next = S_INS_CMP;
      S_INS_MERGE:   state_next = S_INS_NX;
      S_INS_NX: begin
        if (nx_adj && n != LINK_W'(end_mark)) state_next = S_INS_NXRD;
        else                                  state_next = S_INS_WCUR;
      end
      S_INS_NXRD:    state_next = S_INS_WCUR;
      S_INS_WCUR:    state_next = merged ? S_FINISH : S_INS_LINK;
      S_INS_LINK:    state_next = S_FINISH;
      S_FINISH:      if (res_ready) state_next = S_IDLE;
      default:       state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Outputs: handshake, status and memory port
  always_comb begin
    in_ready        = 1'b0;
    stat.res_valid  = 1'b0;
    stat.heap_ready = heap_ready;
    mem_we          = 1'b0;
    mem_waddr       = blk;
    mem_wdata       = '{size: '0, next: LINK_NONE, alloc: 1'b0};
    mem_raddr       = blk;
    case (state)
      S_IDLE:   in_ready = 1'b1;
      S_FINISH: stat.res_valid = 1'b1;
      S_INIT_END: begin
        mem_we    = 1'b1;
        mem_waddr = end_idx;
      end
      S_INIT_HEAD: begin
        mem_we    = (end_idx != '0);
        mem_waddr = '0;
        mem_wdata = '{size: end_slots[SIZE_W-1:0], next: LINK_W'(end_idx), alloc: 1'b0};
      end
      S_ALLOC_LINK: begin
        mem_we    = !prev_start;
        mem_waddr = prev;
        mem_wdata = '{size: prev_hdr.size, next: blk_hdr.next, alloc: prev_hdr.alloc};
      end
      S_ALLOC_BLK: begin
        mem_we    = 1'b1;
        mem_waddr = blk;
        mem_wdata = '{size: final_size, next: LINK_NONE, alloc: 1'b1};
      end
      S_ALLOC_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = nb;
        mem_wdata = '{size: diff, next: LINK_NONE, alloc: 1'b0};
      end
      S_FREE_CHK: begin
        mem_we    = !free_bad;
        mem_waddr = blk;
        mem_wdata = '{size: mem_rdata.size, next: LINK_NONE, alloc: 1'b0};
      end
      S_INS_CMP: mem_raddr = n[SLOT_W-1:0];
      S_INS_NX:  mem_raddr = n[SLOT_W-1:0];
      S_INS_WCUR: begin
        mem_we    = 1'b1;
        mem_waddr = cur;
        mem_wdata = '{size: cursz, next: curnext, alloc: 1'b0};
      end
      S_INS_LINK: begin
        mem_we    = !it_start;
        mem_waddr = it;
        mem_wdata = '{size: it_hdr.size, next: LINK_W'(ins_blk), alloc: it_hdr.alloc};
      end
      default: ;
    endcase
  end

  always_comb begin
    res_data.status         = res_status;
    res_data.address        = res_addr;
    res_data.free_bytes     = bytes_free;
    res_data.min_free_bytes = min_free;
  end

  // --------------------------------------------------------------------------
  // Heap control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      end_mark   <= '0;
      bytes_free <= '0;
      min_free   <= '0;
      heap_ready <= 1'b0;
    end else begin
      case (state)
        S_INIT_END: end_mark <= end_idx;
        S_INIT_HEAD: begin
          heap_ready <= 1'b1;
          if (end_idx != '0) begin
            head       <= '0;
            bytes_free <= endoff;
            min_free   <= endoff;
          end else begin
            head       <= LINK_W'(end_idx);
            bytes_free <= '0;
            min_free   <= '0;
          end
        end
        S_ALLOC_LINK: if (prev_start) head <= blk_hdr.next;
        S_ALLOC_BLK: begin
          bytes_free <= free_after_alloc;
          if (free_after_alloc < min_free) min_free <= free_after_alloc;
        end
        S_FREE_CHK: begin
          if (!free_bad) bytes_free <= bytes_free + {mem_rdata.size, {ALIGN_W{1'b0}}};
        end
        S_INS_LINK: if (it_start) head <= LINK_W'(ins_blk);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Walk datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (in_valid) req <= in_data;
      S_DISPATCH: begin
        res_status <= ST_DONE;
        res_addr   <= '0;
        want_slots <= SIZE_W'(want_rnd >> ALIGN_W);
        blk        <= (req.action == ACT_ALLOC) ? head[SLOT_W-1:0] : free_blk;
        prev_start <= 1'b1;
        if (req.action == ACT_ALLOC) begin
          if (want_fail) res_status <= ST_ALLOC_FAIL;
        end else if (req.block_address != '0 && addr_bad) begin
          res_status <= ST_FREE_REJECT;
        end
      end
      S_ALLOC_CHK: begin
        blk_hdr <= mem_rdata;
        if (chk_continue) begin
          prev       <= blk;
          prev_hdr   <= mem_rdata;
          prev_start <= 1'b0;
          blk        <= mem_rdata.next[SLOT_W-1:0];
        end else if (chk_fail) begin
          res_status <= ST_ALLOC_FAIL;
        end else begin
          res_addr <= alloc_addr;
        end
      end
      S_ALLOC_SPLIT: begin
        ins_blk  <= nb;
        ins_size <= diff;
      end
      S_FREE_CHK: begin
        ins_blk  <= blk;
        ins_size <= mem_rdata.size;
        if (free_bad) res_status <= ST_FREE_REJECT;
      end
      S_INS_START: begin
        it_start <= 1'b1;
        n        <= head;
      end
      S_INS_CMP: begin
        if (n_lt) begin
          it       <= n[SLOT_W-1:0];
          it_start <= 1'b0;
        end
      end
      S_INS_WALK: begin
        it_hdr <= mem_rdata;
        n      <= mem_rdata.next;
      end
      S_INS_MERGE: begin
        merged <= it_adj;
        if (it_adj) begin
          cur   <= it;
          cursz <= it_hdr.size + ins_size;
        end else begin
          cur   <= ins_blk;
          cursz <= ins_size;
        end
      end
      S_INS_NX: begin
        if (!nx_adj)                       curnext <= n;
        else if (n == LINK_W'(end_mark))   curnext <= n;
      end
      S_INS_NXRD: begin
        cursz   <= cursz + mem_rdata.size;
        curnext <= mem_rdata.next;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: design/first_fit_coalescing_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator_unit: first-fit heap allocator
// Configuration registers, sequencer and the output result register.
// ----------------------------------------------------------------------------
// Usage: the first request after reset lays out the heap (the end marker
// header, then the first block's header when the heap is not empty) and
// freezes the configuration registers until the next reset. One request is
// worked at a time; its time is set by the free-list walk through the single
// header memory, one header read per block visited. An allocate walks the
// list to the first fit, unlinks it and marks it allocated; a split tail
// goes back to the list by an address-ordered walk that merges neighbours.
// A free checks and clears its block header, then inserts it the same way.
// Requests ended at decode (zero size, too large, bad address, free of
// zero) skip the walk; a free rejected on its header ends after reading it.
// The sequencer passes through idle before the next request is taken. The
// result sits in an output register, so a new request is taken while the
// previous result waits.
module first_fit_coalescing_allocator_unit import ffca_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data
);

  cfg_t       cfg;
  ctrl_stat_t stat;
  out_t       res_data;
  logic       res_ready;

  // Configuration registers, frozen once the heap is built
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heap_base    <= '0;
      cfg.heap_bytes   <= 17'(HEAP_BYTES_MAX);
      cfg.header_bytes <= 7'd8;
    end else if (cfg_we && !stat.heap_ready) begin
      case (cfg_index)
        CFG_HEAP_BASE:    cfg.heap_base    <= cfg_data;
        CFG_HEAP_BYTES:   cfg.heap_bytes   <= cfg_data[16:0];
        CFG_HEADER_BYTES: cfg.header_bytes <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  ffca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_ready (res_ready),
    .res_data  (res_data),
    .stat      (stat)
  );

  // Output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= stat.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && stat.res_valid) begin
      out_data <= res_data;
    end
  end

endmodule
`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for first_fit_coalescing_allocator_unit
// A short directed table, then random allocate and free beats.
// Each accepted request goes through a local model of the first-fit heap,
// and every result beat is checked field by field against the oldest
// prediction. Both channels idle and stall at random, in phases.
// ----------------------------------------------------------------------------
module tb;
  import ffca_pkg::*;

  localparam int unsigned NO_LINK   = 32'hFFFF_FFFF;
  localparam int unsigned LIST_HEAD = 32'hFFFF_FFFE;
  localparam int          STALL_MAX = 200000;
  localparam int          N_RANDOM  = 930;

  typedef enum int {
    R_ALLOC, R_ALLOC_ALL, R_FREE_ADDR, R_FREE_LIVE, R_FREE_AGAIN, R_FREE_SKEW
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [15:0] size;
    logic [31:0] addr;
    bit          typed;
    status_t     st;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_HEAP_BASE;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;

  first_fit_coalescing_allocator_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Heap shadow state
  int unsigned hsize  [SLOTS];
  int unsigned hnext  [SLOTS];
  bit          halloc [SLOTS];
  bit          hwrit  [SLOTS];
  int unsigned fl_head, end_slot, free_cnt, free_min;
  bit          heap_up;
  int unsigned m_base, m_bytes, m_hdr;

  out_t        expected_beats[$];
  logic [31:0] live_blocks[$];
  logic [31:0] freed_blocks[$];
  int          errors = 0;
  int          tx_idle = 0;
  int          rx_stall = 0;

  function automatic int unsigned sx(int unsigned i);
    return (i < SLOTS) ? i : 0;
  endfunction

  function automatic int unsigned link_of(int unsigned i);
    return (i == LIST_HEAD) ? fl_head : hnext[sx(i)];
  endfunction

  function automatic void set_link(int unsigned i, int unsigned n);
    if (i == LIST_HEAD) fl_head = n;
    else begin
      hnext[sx(i)] = n;
      hwrit[sx(i)] = 1'b1;
    end
  endfunction

  function automatic longint unsigned abase();
    return (longint'(m_base) + ALIGN_BYTES - 1) & ~longint'(ALIGN_BYTES - 1);
  endfunction

  function automatic void lay_out_heap();
    longint unsigned adj, total, endoff;
    adj = abase() - m_base;
    total = (m_bytes > HEAP_BYTES_MAX) ? HEAP_BYTES_MAX : m_bytes;
    total = (total > adj) ? total - adj : 0;
    endoff = (total > m_hdr) ? ((total - m_hdr) & ~longint'(ALIGN_BYTES - 1)) : 0;
    end_slot = endoff / ALIGN_BYTES;
    if (end_slot >= SLOTS) end_slot = 0;
    hsize[end_slot] = 0; hnext[end_slot] = NO_LINK; halloc[end_slot] = 0;
    hwrit[end_slot] = 1;
    if (endoff > 0 && end_slot != 0) begin
      hsize[0] = endoff; hnext[0] = end_slot; halloc[0] = 0; hwrit[0] = 1;
      fl_head = 0;
      free_cnt = endoff & 32'h1FFFF;
    end else begin
      fl_head = end_slot;
      free_cnt = 0;
    end
    free_min = free_cnt;
    heap_up = 1;
  endfunction

  // Put a block back in address order, merging with neighbors
  function automatic void link_free(int unsigned blk);
    int unsigned it, guard, nx;
    it = LIST_HEAD; guard = 0;
    while (link_of(it) < blk && guard <= SLOTS) begin
      it = link_of(it);
      guard++;
    end
    if (it != LIST_HEAD &&
        longint'(it) * ALIGN_BYTES + hsize[sx(it)] == longint'(blk) * ALIGN_BYTES) begin
      hsize[sx(it)] += hsize[sx(blk)];
      blk = it;
    end
    nx = link_of(it);
    if (nx != NO_LINK &&
        longint'(blk) * ALIGN_BYTES + hsize[sx(blk)] == longint'(nx) * ALIGN_BYTES) begin
      if (nx != end_slot) begin
        hsize[sx(blk)] += hsize[sx(nx)];
        set_link(blk, hnext[sx(nx)]);
      end else set_link(blk, end_slot);
    end else set_link(blk, nx);
    if (it != blk) set_link(it, blk);
  endfunction

  function automatic status_t heap_alloc(int unsigned req, output logic [31:0] addr);
    int unsigned want, prev, blk, guard, nb;
    want = 0; prev = LIST_HEAD; guard = 0; addr = '0;
    if (req > 0) begin
      want = req + m_hdr;
      if ((want & (ALIGN_BYTES - 1)) != 0) want += ALIGN_BYTES - (want & (ALIGN_BYTES - 1));
    end
    if (want == 0 || want > free_cnt) return ST_ALLOC_FAIL;
    blk = fl_head;
    while (blk < SLOTS && hsize[sx(blk)] < want && hnext[sx(blk)] != NO_LINK &&
           guard <= SLOTS) begin
      prev = blk;
      blk = hnext[sx(blk)];
      guard++;
    end
    if (blk >= SLOTS || blk == end_slot || hsize[sx(blk)] < want) return ST_ALLOC_FAIL;
    addr = abase() + longint'(blk) * ALIGN_BYTES + m_hdr;
    set_link(prev, hnext[blk]);
    // split when the tail is worth keeping
    if (hsize[blk] - want > 2 * m_hdr) begin
      nb = blk + want / ALIGN_BYTES;
      hsize[sx(nb)] = hsize[blk] - want;
      halloc[sx(nb)] = 0;
      hnext[sx(nb)] = NO_LINK;
      hwrit[sx(nb)] = 1;
      hsize[blk] = want;
      link_free(nb);
    end
    free_cnt = (free_cnt - hsize[blk]) & 32'h1FFFF;
    if (free_cnt < free_min) free_min = free_cnt;
    halloc[blk] = 1;
    hnext[blk] = NO_LINK;
    return ST_DONE;
  endfunction

  function automatic status_t heap_free(logic [31:0] addr);
    longint unsigned low, rel;
    int unsigned blk;
    low = abase() + m_hdr;
    if (addr == 0) return ST_DONE;
    if (longint'(addr) < low) return ST_FREE_REJECT;
    rel = longint'(addr) - low;
    if ((rel & (ALIGN_BYTES - 1)) != 0 || rel / ALIGN_BYTES >= SLOTS) return ST_FREE_REJECT;
    blk = rel / ALIGN_BYTES;
    if (!halloc[blk] || hnext[blk] != NO_LINK) return ST_FREE_REJECT;
    halloc[blk] = 0;
    free_cnt = (free_cnt + hsize[blk]) & 32'h1FFFF;
    link_free(blk);
    return ST_DONE;
  endfunction

  function automatic out_t heap_step(in_t d);
    out_t r;
    logic [31:0] a;
    a = '0;
    if (!heap_up) lay_out_heap();
    if (d.action == ACT_ALLOC) r.status = heap_alloc(d.request_size, a);
    else r.status = heap_free(d.block_address);
    r.address = (r.status == ST_DONE) ? a : '0;
    r.free_bytes = free_cnt[16:0];
    r.min_free_bytes = free_min[16:0];
    return r;
  endfunction

  function automatic void model_cfg(logic [1:0] idx, logic [31:0] val);
    if (heap_up) return;
    case (idx)
      CFG_HEAP_BASE:    m_base = val;
      CFG_HEAP_BYTES:   m_bytes = val & 32'h1FFFF;
      CFG_HEADER_BYTES: m_hdr = val & 32'h7F;
      default: ;
    endcase
  endfunction

  // True when a free of this address would read a header never written
  function automatic bit hits_blank(logic [31:0] addr);
    longint unsigned low, rel;
    low = abase() + m_hdr;
    if (addr == 0 || longint'(addr) < low) return 0;
    rel = longint'(addr) - low;
    if ((rel & (ALIGN_BYTES - 1)) != 0 || rel / ALIGN_BYTES >= SLOTS) return 0;
    return !hwrit[rel / ALIGN_BYTES];
  endfunction

  // One register write; the caller drops cfg_we after the last one
  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    model_cfg(idx, val);
  endtask

  // Drive one request beat, predict it once accepted
  task automatic send(in_t d, bit typed, status_t st);
    out_t e;
    int k;
    if (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    e = heap_step(d);
    if (typed) e.status = st;
    expected_beats.push_back(e);
    if (d.action == ACT_ALLOC && e.status == ST_DONE) live_blocks.push_back(e.address);
    if (d.action == ACT_FREE && e.status == ST_DONE && d.block_address != 0) begin
      for (k = 0; k < live_blocks.size(); k++)
        if (live_blocks[k] == d.block_address) begin
          live_blocks.delete(k);
          break;
        end
      freed_blocks.push_back(d.block_address);
      if (freed_blocks.size() > 64) void'(freed_blocks.pop_front());
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic row_t mk(row_kind_t k, logic [15:0] s, logic [31:0] a, bit t,
                              status_t st);
    row_t r;
    r.kind = k; r.size = s; r.addr = a; r.typed = t; r.st = st;
    return r;
  endfunction

  // Turn a table row into a request beat using the current heap view
  function automatic in_t row_beat(row_t r);
    in_t d;
    int unsigned j;
    d.action = ACT_FREE;
    d.request_size = $urandom;
    d.block_address = r.addr;
    case (r.kind)
      R_ALLOC: begin
        d.action = ACT_ALLOC; d.request_size = r.size; d.block_address = $urandom;
      end
      R_ALLOC_ALL: begin
        d.action = ACT_ALLOC;
        d.request_size = (free_cnt > m_hdr) ? free_cnt - m_hdr : 1;
      end
      R_FREE_LIVE: begin
        if (live_blocks.size() == 0) d.block_address = 0;
        else begin
          j = (r.addr == 0) ? 0 : live_blocks.size() - 1;
          d.block_address = live_blocks[j];
        end
      end
      R_FREE_AGAIN: d.block_address = (freed_blocks.size() != 0) ? freed_blocks[$] : 1;
      R_FREE_SKEW:  d.block_address = abase() + m_hdr + 1;
      default: ;
    endcase
    return d;
  endfunction

  row_t plan[$];

  initial begin
    in_t d;
    row_t r;
    int i, ph, pick;
    int unsigned sz;
    int idle_pct[4] = '{0, 59, 0, 22};
    int stall_pct[4] = '{0, 0, 59, 22};

    m_base = 0; m_bytes = 65536; m_hdr = 8;
    heap_up = 0; fl_head = 0; end_slot = 0; free_cnt = 0; free_min = 0;
    for (i = 0; i < SLOTS; i++) begin
      hsize[i] = 0; hnext[i] = 0; halloc[i] = 0; hwrit[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The only setting that counts: the heap is frozen by its first request
    cfg_write(CFG_HEAP_BASE, $urandom & 32'h00FF_FFFF);
    cfg_write(CFG_HEAP_BYTES, $urandom_range(65536, 1024));
    cfg_write(CFG_HEADER_BYTES, $urandom_range(64, 8));
    cfg_we <= 1'b0;

    // Directed table
    plan.push_back(mk(R_FREE_ADDR, 0, 0, 1, ST_DONE));           // builds the heap
    plan.push_back(mk(R_ALLOC, 0, 0, 1, ST_ALLOC_FAIL));         // zero request
    plan.push_back(mk(R_ALLOC, 16'hFFFF, 0, 1, ST_ALLOC_FAIL));  // too large
    plan.push_back(mk(R_ALLOC, 1, 0, 1, ST_DONE));
    plan.push_back(mk(R_ALLOC, 16, 0, 1, ST_DONE));
    plan.push_back(mk(R_ALLOC, 200, 0, 1, ST_DONE));
    plan.push_back(mk(R_ALLOC, 7, 0, 1, ST_DONE));
    plan.push_back(mk(R_FREE_LIVE, 0, 0, 1, ST_DONE));
    plan.push_back(mk(R_FREE_AGAIN, 0, 0, 1, ST_FREE_REJECT));   // not allocated
    plan.push_back(mk(R_FREE_ADDR, 0, 1, 1, ST_FREE_REJECT));    // below the heap
    plan.push_back(mk(R_FREE_SKEW, 0, 0, 1, ST_FREE_REJECT));    // misaligned
    plan.push_back(mk(R_FREE_ADDR, 0, 32'hFFFF_FFFF, 1, ST_FREE_REJECT)); // past store
    plan.push_back(mk(R_FREE_LIVE, 0, 1, 0, ST_DONE));
    plan.push_back(mk(R_FREE_LIVE, 0, 0, 0, ST_DONE));
    plan.push_back(mk(R_ALLOC, 8, 0, 0, ST_DONE));
    plan.push_back(mk(R_ALLOC, 24, 0, 0, ST_DONE));
    plan.push_back(mk(R_FREE_LIVE, 0, 0, 0, ST_DONE));
    plan.push_back(mk(R_FREE_LIVE, 0, 0, 0, ST_DONE));
    plan.push_back(mk(R_FREE_LIVE, 0, 0, 0, ST_DONE));
    plan.push_back(mk(R_ALLOC_ALL, 0, 0, 0, ST_DONE));           // whole heap
    plan.push_back(mk(R_ALLOC, 1, 0, 0, ST_DONE));
    plan.push_back(mk(R_FREE_LIVE, 0, 1, 0, ST_DONE));
    plan.push_back(mk(R_FREE_LIVE, 0, 0, 0, ST_DONE));
    foreach (plan[k]) begin
      r = plan[k];
      d = row_beat(r);
      send(d, r.typed, r.st);
    end
    drain();

    // Random traffic in idling phases
    for (ph = 0; ph < 4; ph++) begin
      tx_idle = idle_pct[ph];
      rx_stall = stall_pct[ph];
      // Late writes land on a frozen heap; cover the register extremes
      cfg_write(CFG_HEAP_BASE, (ph[0]) ? 32'hFFFF_FFFF : 32'h0);
      cfg_write(CFG_HEAP_BYTES, (ph[0]) ? 32'd64 : 32'd65536);
      cfg_write(CFG_HEADER_BYTES, (ph[0]) ? 32'd64 : 32'd8);
      cfg_we <= 1'b0;
      for (i = 0; i < N_RANDOM / 4; i++) begin
        pick = $urandom_range(99);
        d.request_size = $urandom;
        d.block_address = $urandom;
        if (pick < 55) begin
          d.action = ACT_ALLOC;
          sz = $urandom_range(9);
          if (sz < 6) d.request_size = $urandom_range(64, 1);
          else if (sz < 9) d.request_size = $urandom_range(2048, 1);
          else if ($urandom_range(1)) d.request_size = 0;
        end else begin
          d.action = ACT_FREE;
          if (pick < 90 && live_blocks.size() != 0)
            d.block_address = live_blocks[$urandom_range(live_blocks.size() - 1)];
          else if (pick < 93) d.block_address = 0;
          else if (pick < 96 && freed_blocks.size() != 0)
            d.block_address = freed_blocks[$urandom_range(freed_blocks.size() - 1)];
          if (hits_blank(d.block_address)) d.block_address = abase() + m_hdr + 1;
        end
        send(d, 0, ST_DONE);
      end
      drain();
    end

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Result side: random stalls and the field check
  always @(posedge clk) begin
    out_t e;
    if (!rst) begin
      out_ready <= (rx_stall == 0) || ($urandom_range(99) >= rx_stall);
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with no request pending");
          errors++;
        end else begin
          e = expected_beats.pop_front();
          if (out_data.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_data.status);
            errors++;
          end
          if (out_data.address !== e.address) begin
            $error("address: expected %h, got %h", e.address, out_data.address);
            errors++;
          end
          if (out_data.free_bytes !== e.free_bytes) begin
            $error("free_bytes: expected %0d, got %0d", e.free_bytes, out_data.free_bytes);
            errors++;
          end
          if (out_data.min_free_bytes !== e.min_free_bytes) begin
            $error("min_free_bytes: expected %0d, got %0d", e.min_free_bytes,
                   out_data.min_free_bytes);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == STALL_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

// File: filelist.f
design/ffca_pkg.sv
design/ffca_hdr_ram.sv
design/ffca_ctrl.sv
design/first_fit_coalescing_allocator_unit.sv
sim/tb.sv
